[rtl/rita_pkg.sv]
// ----------------------------------------------------------------------------
// rita_pkg: shared types and constants for the radix integer-to-ASCII block
// Default sizes, radix limits, divider handshake structs, digit lookup.
// ----------------------------------------------------------------------------
package rita_pkg;

	// default sizes
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int MAX_DIGITS_DEF  = 32;

	// input field widths
	localparam int VALUE_PORT_W = 32;
	localparam int RADIX_W      = 5;
	localparam int DIGIT_W      = 4;
	localparam int CHAR_W       = 8;

	// radix limits
	localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 5'd16;

	// quotient bits resolved per divider cycle
	localparam int STEP_BITS = 4;

	// divider request
	typedef struct packed {
		logic               load;
		logic [RADIX_W-1:0] base;
	} rita_div_ctl_t;

	// divider status
	typedef struct packed {
		logic               done;
		logic [DIGIT_W-1:0] rem;
	} rita_div_stat_t;

	// digit character set
	localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
		8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
		8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
	};

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		return DIGIT_CHARS[d];
	endfunction

endpackage

[rtl/rita_divider.sv]
// ----------------------------------------------------------------------------
// rita_divider: iterative divide by a small base
// Restoring division, STEP_BITS quotient bits per cycle; pulses done with
// quotient and remainder held until the next load.
// ----------------------------------------------------------------------------
module rita_divider #(
	parameter int WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  rita_pkg::rita_div_ctl_t ctl,
	input  logic [WIDTH-1:0]       dividend,
	output logic [WIDTH-1:0]       quotient,
	output rita_pkg::rita_div_stat_t stat
);
	import rita_pkg::*;

	localparam int STEPS = WIDTH / STEP_BITS;
	localparam int CW    = (STEPS > 1) ? $clog2(STEPS) : 1;

	logic             active_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH-1:0] quot_q;
	logic [RADIX_W-1:0] rem_q;
	logic [RADIX_W-1:0] base_q;
	logic [WIDTH-1:0] quot_nxt;
	logic [RADIX_W-1:0] rem_nxt;

	// STEP_BITS restoring steps: shift in next dividend bit, subtract if fits
	always_comb begin
		rem_nxt  = rem_q;
		quot_nxt = quot_q;
		for (int i = 0; i < STEP_BITS; i++) begin
			rem_nxt  = {rem_nxt[RADIX_W-2:0], quot_nxt[WIDTH-1]};
			quot_nxt = {quot_nxt[WIDTH-2:0], 1'b0};
			if (rem_nxt >= base_q) begin
				rem_nxt     = rem_nxt - base_q;
				quot_nxt[0] = 1'b1;
			end
		end
	end

	// sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.load) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				if (cnt_q == CW'(STEPS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quot_q <= dividend;
			rem_q  <= '0;
			base_q <= ctl.base;
		end else if (active_q) begin
			quot_q <= quot_nxt;
			rem_q  <= rem_nxt;
		end
	end

	assign quotient  = quot_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q[DIGIT_W-1:0];

	// checks
	a_rem_below_base: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (rem_q < base_q))
		else $error("remainder not below base");
	a_load_base_range: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> (ctl.base >= RADIX_MIN && ctl.base <= RADIX_MAX))
		else $error("divider loaded with base out of range");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !active_q)
		else $error("done raised while still dividing");

endmodule

[rtl/rita_digit_mem.sv]
// ----------------------------------------------------------------------------
// rita_digit_mem: digit buffer
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rita_digit_mem #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [rita_pkg::DIGIT_W-1:0] wdata,
	input  logic                         re,
	input  logic [AW-1:0]                raddr,
	output logic [rita_pkg::DIGIT_W-1:0] rdata
);
	import rita_pkg::*;

	logic [DIGIT_W-1:0] mem [DEPTH];
	logic [DIGIT_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/radix_integer_to_ascii.sv]
// ----------------------------------------------------------------------------
// radix_integer_to_ascii: unsigned integer to ASCII digits in base 2..16
// Converts a value by repeated division and emits lower-case digit chars.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive value and radix with start high while busy is low; the
//   request is taken at that edge. busy stays high until the last digit has
//   been read out of the digit buffer. radix below 2 acts as 2, above 16 as 16.
//   Results: each character is marked by char_strobe, most significant
//   first; last_digit flags the final (least significant) character. Zero
//   gives the single character '0'. Results cannot be stalled.
// Sequence:
//   Each digit costs one load and one pass of the shared divider over
//   W = min(VALUE_WIDTH, 32) bits, rounded up to a multiple of 4. Emission
//   reads each digit from the buffer, then registers it for output. A new
//   request may start in the cycle the final character is shown.
// Reset: arst_n returns the sequencer to idle and drops char_strobe.
// ----------------------------------------------------------------------------
module radix_integer_to_ascii #(
	parameter int VALUE_WIDTH = rita_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = rita_pkg::MAX_DIGITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [rita_pkg::VALUE_PORT_W-1:0] value,
	input  logic [rita_pkg::RADIX_W-1:0]      radix,
	output logic                              char_strobe,
	output logic [rita_pkg::CHAR_W-1:0]       ascii_char,
	output logic                              last_digit
);
	import rita_pkg::*;

	localparam int W  = (VALUE_WIDTH < VALUE_PORT_W) ? VALUE_WIDTH : VALUE_PORT_W;
	localparam int WP = ((W + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
	localparam int AW = $clog2(MAX_DIGITS);
	localparam int NW = $clog2(MAX_DIGITS + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_SHOW
	} state_t;

	state_t             state_q;
	logic [NW-1:0]      n_q;
	logic [AW-1:0]      idx_q;
	logic [RADIX_W-1:0] base_q;
	logic               strobe_q;
	logic [CHAR_W-1:0]  char_q;
	logic               last_q;

	logic [RADIX_W-1:0] base_in;
	logic               accept;
	logic               room;
	logic               div_last;
	rita_div_ctl_t      div_ctl;
	rita_div_stat_t     div_stat;
	logic [WP-1:0]      div_dividend;
	logic [WP-1:0]      div_quot;
	logic               mem_we;
	logic               mem_re;
	logic [DIGIT_W-1:0] mem_rdata;

	// clamp the requested base
	always_comb begin
		priority if (radix < RADIX_MIN) begin
			base_in = RADIX_MIN;
		end else if (radix > RADIX_MAX) begin
			base_in = RADIX_MAX;
		end else begin
			base_in = radix;
		end
	end

	assign accept   = start && (state_q == ST_IDLE);
	assign room     = (n_q < NW'(MAX_DIGITS));
	assign div_last = (div_quot == '0);

	// divider requests: first from the input, then from the last quotient
	always_comb begin
		div_ctl.load = accept ||
			((state_q == ST_DIV) && div_stat.done && !div_last);
		div_ctl.base = accept ? base_in : base_q;
		div_dividend = accept ? WP'(value[W-1:0]) : div_quot;
	end

	rita_divider #(
		.WIDTH(WP)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (div_ctl),
		.dividend(div_dividend),
		.quotient(div_quot),
		.stat    (div_stat)
	);

	// digit buffer, least significant digit at index zero
	assign mem_we = (state_q == ST_DIV) && div_stat.done && room;
	assign mem_re = (state_q == ST_READ);

	rita_digit_mem #(
		.DEPTH(MAX_DIGITS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(n_q[AW-1:0]),
		.wdata(div_stat.rem),
		.re   (mem_re),
		.raddr(idx_q),
		.rdata(mem_rdata)
	);

	// sequencer and output registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			n_q      <= '0;
			idx_q    <= '0;
			base_q   <= RADIX_MIN;
			strobe_q <= 1'b0;
			last_q   <= 1'b0;
			char_q   <= '0;
		end else begin
			strobe_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						n_q     <= '0;
						base_q  <= base_in;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						if (room) begin
							n_q <= n_q + 1'b1;
						end
						if (div_last) begin
							idx_q   <= room ? n_q[AW-1:0] : AW'(n_q - 1'b1);
							state_q <= ST_READ;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_SHOW;
				end
				ST_SHOW: begin
					strobe_q <= 1'b1;
					char_q   <= digit_char(mem_rdata);
					last_q   <= (idx_q == '0);
					if (idx_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != ST_IDLE);
	assign char_strobe = strobe_q;
	assign ascii_char  = char_q;
	assign last_digit  = last_q;

	// checks
	a_strobe_from_show: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> $past(state_q == ST_SHOW))
		else $error("character shown without a buffer read");
	a_read_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_READ) |-> (n_q != '0))
		else $error("readout started with an empty digit buffer");
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("busy not raised after request");
	a_char_legal: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q |-> ((char_q >= 8'h30 && char_q <= 8'h39) ||
			(char_q >= 8'h61 && char_q <= 8'h66)))
		else $error("character outside digit set");

endmodule
